[rtl/sdbv_pkg.sv]
// Shared types, codes and constants of the steepest-descent basin value block.
`default_nettype none
package sdbv_pkg;

    localparam int DEF_MAX_ROWS = 256;
    localparam int DEF_MAX_COLS = 256;

    localparam int VAL_W     = 32;
    localparam int POS_W     = 8;
    localparam int DIM_W     = 9;
    localparam int CFG_IDX_W = 8;

    localparam logic             CMD_LOAD  = 1'b0;
    localparam logic             CMD_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 8'd1;

    localparam logic [DIM_W-1:0] RST_GRID_DIM = 9'd256;

    // Neighbor order N, S, W, E, NW, NE, SW, SE.
    localparam logic signed [1:0] STEP_DR [8] = '{-2'sd1, 2'sd1, 2'sd0, 2'sd0,
                                                  -2'sd1, -2'sd1, 2'sd1, 2'sd1};
    localparam logic signed [1:0] STEP_DC [8] = '{2'sd0, 2'sd0, -2'sd1, 2'sd1,
                                                  -2'sd1, 2'sd1, -2'sd1, 2'sd1};

    typedef struct packed {
        logic load_wr;
        logic query_start;
        logic center_rd;
        logic center_latch;
        logic scan_issue;
        logic step_apply;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic bad;
        logic scan_last;
        logic moved;
        logic out_busy;
    } t_sts;

endpackage
`default_nettype wire

[rtl/sdbv_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sdbv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[rtl/sdbv_ctrl.sv]
// Controller state machine sequencing loads and descent walks.
`default_nettype none
module sdbv_ctrl
    import sdbv_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_in_cmd,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_CWAIT = 7'b0000100,
        S_SCAN  = 7'b0001000,
        S_DRAIN = 7'b0010000,
        S_STEP  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_cmd == CMD_LOAD) begin
                        o_cmd.load_wr = 1'b1;
                    end else begin
                        o_cmd.query_start = 1'b1;
                        n_state           = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (i_sts.bad) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.center_rd = 1'b1;
                    n_state         = S_CWAIT;
                end
            end
            S_CWAIT: begin
                o_cmd.center_latch = 1'b1;
                n_state            = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last neighbor compares this cycle
                n_state = S_STEP;
            end
            S_STEP: begin
                if (i_sts.moved) begin
                    o_cmd.step_apply = 1'b1;
                    n_state          = S_SCAN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

[rtl/sdbv_dp.sv]
// Datapath: height store, walk position, neighbor scan, compare and output register.
`default_nettype none
module sdbv_dp
    import sdbv_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire t_cmd                        i_cmd,
    output t_sts                             o_sts,
    input  wire logic        [POS_W-1:0]     i_row,
    input  wire logic        [POS_W-1:0]     i_col,
    input  wire logic signed [VAL_W-1:0]     i_cell_value,
    input  wire logic                        i_cfg_valid,
    input  wire logic        [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic        [DIM_W-1:0]     i_cfg_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic signed      [VAL_W-1:0]     o_basin_value,
    output logic                             o_bad_address
);

    localparam int DEPTH   = MAX_ROWS * MAX_COLS;
    localparam int AW      = $clog2(DEPTH);
    localparam int ROW_CAP = (MAX_ROWS > 511) ? 511 : MAX_ROWS;
    localparam int COL_CAP = (MAX_COLS > 511) ? 511 : MAX_COLS;

    function automatic logic [AW-1:0] f_addr(input logic [DIM_W-1:0] row,
                                             input logic [DIM_W-1:0] col);
        logic [31:0] lin;
        lin = 32'(row) * 32'(MAX_COLS) + 32'(col);
        return lin[AW-1:0];
    endfunction

    logic        [DIM_W-1:0] r_grid_rows;
    logic        [DIM_W-1:0] r_grid_cols;
    logic        [DIM_W-1:0] eff_rows;
    logic        [DIM_W-1:0] eff_cols;

    logic        [DIM_W-1:0] r_cur_row;
    logic        [DIM_W-1:0] r_cur_col;
    logic        [DIM_W-1:0] r_best_row;
    logic        [DIM_W-1:0] r_best_col;
    logic signed [VAL_W-1:0] r_best_val;
    logic                    r_moved;
    logic                    r_bad;
    logic        [2:0]       r_k;

    logic                    r_cmp_valid;
    logic        [DIM_W-1:0] r_cmp_row;
    logic        [DIM_W-1:0] r_cmp_col;

    logic                    r_out_valid;
    logic signed [VAL_W-1:0] r_out_basin;
    logic                    r_out_bad;

    logic signed [10:0]      nbr_r;
    logic signed [10:0]      nbr_c;
    logic                    nbr_ok;
    logic                    load_in_store;
    logic                    query_bad;
    logic                    take_lower;
    logic        [AW-1:0]    ram_waddr;
    logic        [AW-1:0]    ram_raddr;
    logic        [VAL_W-1:0] ram_rdata;
    logic signed [VAL_W-1:0] rd_val;

    assign eff_rows = (r_grid_rows > DIM_W'(ROW_CAP)) ? DIM_W'(ROW_CAP) : r_grid_rows;
    assign eff_cols = (r_grid_cols > DIM_W'(COL_CAP)) ? DIM_W'(COL_CAP) : r_grid_cols;

    assign load_in_store = (32'(i_row) < 32'(MAX_ROWS)) && (32'(i_col) < 32'(MAX_COLS));
    assign query_bad     = ({1'b0, i_row} >= eff_rows) || ({1'b0, i_col} >= eff_cols);

    assign nbr_r  = $signed({2'b00, r_cur_row}) + 11'(STEP_DR[r_k]);
    assign nbr_c  = $signed({2'b00, r_cur_col}) + 11'(STEP_DC[r_k]);
    assign nbr_ok = !nbr_r[10] && !nbr_c[10]
                    && (nbr_r[9:0] < {1'b0, eff_rows})
                    && (nbr_c[9:0] < {1'b0, eff_cols});

    assign ram_waddr = f_addr({1'b0, i_row}, {1'b0, i_col});
    assign ram_raddr = i_cmd.center_rd ? f_addr(r_cur_row, r_cur_col)
                                       : f_addr(nbr_r[8:0], nbr_c[8:0]);

    sdbv_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_height (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_wr && load_in_store),
        .i_waddr (ram_waddr),
        .i_wdata (i_cell_value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_val     = $signed(ram_rdata);
    // strict compare keeps the earliest neighbor among equal lows
    assign take_lower = r_cmp_valid && (rd_val < r_best_val);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= RST_GRID_DIM;
            r_grid_cols <= RST_GRID_DIM;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_GRID_ROWS) begin
                r_grid_rows <= i_cfg_data;
            end else if (i_cfg_index == REG_GRID_COLS) begin
                r_grid_cols <= i_cfg_data;
            end
        end
    end

    // walk control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_valid <= 1'b0;
            r_moved     <= 1'b0;
            r_k         <= '0;
            r_bad       <= 1'b0;
        end else begin
            r_cmp_valid <= i_cmd.scan_issue && nbr_ok;
            if (i_cmd.query_start) begin
                r_bad <= query_bad;
            end
            if (i_cmd.center_latch || i_cmd.step_apply) begin
                r_k     <= '0;
                r_moved <= 1'b0;
            end else begin
                if (i_cmd.scan_issue) begin
                    r_k <= r_k + 3'd1;
                end
                if (take_lower) begin
                    r_moved <= 1'b1;
                end
            end
        end
    end

    // walk payload
    always_ff @(posedge i_clk) begin
        r_cmp_row <= nbr_r[8:0];
        r_cmp_col <= nbr_c[8:0];
        if (i_cmd.query_start) begin
            r_cur_row <= {1'b0, i_row};
            r_cur_col <= {1'b0, i_col};
        end else if (i_cmd.step_apply) begin
            r_cur_row <= r_best_row;
            r_cur_col <= r_best_col;
        end
        if (i_cmd.center_latch) begin
            r_best_val <= rd_val;
            r_best_row <= r_cur_row;
            r_best_col <= r_cur_col;
        end else if (take_lower) begin
            r_best_val <= rd_val;
            r_best_row <= r_cmp_row;
            r_best_col <= r_cmp_col;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_basin <= r_bad ? '0 : r_best_val;
            r_out_bad   <= r_bad;
        end
    end

    assign o_sts.bad       = r_bad;
    assign o_sts.scan_last = (r_k == 3'd7);
    assign o_sts.moved     = r_moved;
    assign o_sts.out_busy  = r_out_valid && !i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_basin_value = r_out_basin;
    assign o_bad_address = r_out_bad;

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten while a result waits");

    a_cmp_follows_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_valid |-> $past(i_cmd.scan_issue))
        else $error("compare without a neighbor read");

    a_move_new_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_moved |-> (r_best_row != r_cur_row || r_best_col != r_cur_col))
        else $error("move recorded to the current cell");

    a_cfg_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && i_cfg_index == REG_GRID_ROWS) |=> (r_grid_rows == $past(i_cfg_data)))
        else $error("grid_rows write lost");

endmodule
`default_nettype wire

[rtl/steepest_descent_basin_value.sv]
// Top level: steepest-descent basin value over a loaded height grid.
// A load writes the height store and gives no result; a query outside the area goes from
// S_CHECK to S_DONE, where its result is loaded. A query inside it reads its cell in S_CHECK
// and S_CWAIT; each visited cell then costs 8 neighbor reads, a drain and a step on the store's
// single read port. One query at a time is in flight; the next item is taken once it is done.
// Reset (synchronous, active low) sets grid_rows and grid_cols to 256 and clears control state;
// the height store is not cleared and holds whatever loads put there.
`default_nettype none
module steepest_descent_basin_value
    import sdbv_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic                        i_cmd,
    input  wire logic        [POS_W-1:0]     i_row,
    input  wire logic        [POS_W-1:0]     i_col,
    input  wire logic signed [VAL_W-1:0]     i_cell_value,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic signed      [VAL_W-1:0]     o_basin_value,
    output logic                             o_bad_address,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic        [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic        [DIM_W-1:0]     i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    sdbv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_cmd   (i_cmd),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sdbv_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_row         (i_row),
        .i_col         (i_col),
        .i_cell_value  (i_cell_value),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_basin_value (o_basin_value),
        .o_bad_address (o_bad_address)
    );

endmodule
`default_nettype wire

[verif/tb_top.sv]
// Testbench for the steepest-descent basin value block: directed and random loads and queries.
module tb_top
    import sdbv_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MAX_R        = DEF_MAX_ROWS;
    localparam int          MAX_C        = DEF_MAX_COLS;
    localparam int unsigned CELLS        = MAX_R * MAX_C;
    localparam int          ITEM_TARGET  = 1650;
    localparam int          STALL_LIMIT  = 20000;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          MAX_REPORTS  = 100;

    localparam logic signed [VAL_W-1:0] H_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] H_MAX = 32'sh7FFF_FFFF;

    // 3x3 plateau: north and west neighbors of the center tie but drain to different minima.
    localparam int TIE_GRID [9] = '{20, 10, 2, 10, 50, 30, -4, 30, 40};

    typedef enum int {MIX_NARROW, MIX_WIDE, MIX_EDGES} t_height_mix;

    typedef struct {
        logic signed [VAL_W-1:0] value;
        logic                    bad;
    } t_basin;

    logic                        i_clk;
    logic                        i_rst_n     = 1'b0;
    logic                        i_in_valid  = 1'b0;
    logic                        o_in_ready;
    logic                        i_cmd       = CMD_LOAD;
    logic        [POS_W-1:0]     i_row       = '0;
    logic        [POS_W-1:0]     i_col       = '0;
    logic signed [VAL_W-1:0]     i_cell_value = '0;
    logic                        o_out_valid;
    logic                        i_out_ready = 1'b0;
    logic signed [VAL_W-1:0]     o_basin_value;
    logic                        o_bad_address;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic        [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic        [DIM_W-1:0]     i_cfg_data  = '0;

    // Shadow state of the block.
    logic signed [VAL_W-1:0] heights [CELLS];
    logic signed [VAL_W-1:0] memo_value [CELLS];
    int unsigned             memo_stamp [CELLS];
    int unsigned             memo_epoch = 1;
    logic [DIM_W-1:0]        rows_reg = RST_GRID_DIM;
    logic [DIM_W-1:0]        cols_reg = RST_GRID_DIM;

    t_basin pending_basins [$];
    int     items_accepted = 0;
    int     error_count    = 0;
    bit     gaps_on        = 1'b0;
    int     hold_len       = 0;

    steepest_descent_basin_value DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_row         (i_row),
        .i_col         (i_col),
        .i_cell_value  (i_cell_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_basin_value (o_basin_value),
        .o_bad_address (o_bad_address),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned area_rows();
        return (rows_reg > MAX_R) ? MAX_R : int'(rows_reg);
    endfunction

    function automatic int unsigned area_cols();
        return (cols_reg > MAX_C) ? MAX_C : int'(cols_reg);
    endfunction

    // Next cell on the descent path; the cell itself at a local minimum.
    function automatic int unsigned downhill(input int unsigned pos);
        int                      r, c, rr, cc, i;
        int unsigned             nxt;
        logic signed [VAL_W-1:0] low;
        r   = pos / MAX_C;
        c   = pos % MAX_C;
        low = heights[pos];
        nxt = pos;
        for (i = 0; i < 8; i++) begin
            rr = r + int'(STEP_DR[i]);
            cc = c + int'(STEP_DC[i]);
            if (rr >= 0 && cc >= 0 && rr < int'(area_rows()) && cc < int'(area_cols())) begin
                if (heights[rr * MAX_C + cc] < low) begin
                    low = heights[rr * MAX_C + cc];
                    nxt = rr * MAX_C + cc;
                end
            end
        end
        return nxt;
    endfunction

    function automatic t_basin predict_basin(input logic [POS_W-1:0] row,
                                             input logic [POS_W-1:0] col);
        t_basin                  res;
        int unsigned             start, at, nxt, guard;
        logic signed [VAL_W-1:0] answer;
        bit                      hit;
        res.value = '0;
        res.bad   = 1'b0;
        answer    = '0;
        if (row >= area_rows() || col >= area_cols()) begin
            res.bad = 1'b1;
            return res;
        end
        start = row * MAX_C + col;
        // Walk down until a minimum or a memoized cell.
        at = start;
        for (guard = 0; guard <= CELLS; guard++) begin
            if (memo_stamp[at] == memo_epoch) begin
                answer = memo_value[at];
                break;
            end
            nxt = downhill(at);
            if (nxt == at) begin
                answer = heights[at];
                break;
            end
            at = nxt;
        end
        // Write the answer back along the same path.
        at = start;
        for (guard = 0; guard <= CELLS; guard++) begin
            hit            = (memo_stamp[at] == memo_epoch);
            memo_stamp[at] = memo_epoch;
            memo_value[at] = answer;
            if (hit)
                break;
            nxt = downhill(at);
            if (nxt == at)
                break;
            at = nxt;
        end
        res.value = answer;
        return res;
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_height(input t_height_mix mix);
        int sel;
        sel = $urandom_range(0, 3);
        case (mix)
            MIX_NARROW: return $signed($urandom_range(0, 6)) - 3;
            MIX_WIDE:   return $urandom();
            default: begin
                if (sel == 0)
                    return H_MIN;
                else if (sel == 1)
                    return H_MAX;
                else if (sel == 2)
                    return -1;
                return $urandom();
            end
        endcase
    endfunction

    task automatic check_basin_result(input logic signed [VAL_W-1:0] got_value,
                                      input logic got_bad);
        t_basin want;
        if (pending_basins.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: unexpected result: expected none, actual basin %0d bad %0b",
                         $time, got_value, got_bad);
        end else begin
            want = pending_basins.pop_front();
            if (got_bad !== want.bad) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: bad_address mismatch: expected %0b actual %0b",
                             $time, want.bad, got_bad);
            end
            if (got_value !== want.value) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: basin_value mismatch: expected %0d actual %0d",
                             $time, want.value, got_value);
            end
        end
    endtask

    task automatic offer_item(input logic cmd, input logic [POS_W-1:0] row,
                              input logic [POS_W-1:0] col,
                              input logic signed [VAL_W-1:0] value);
        int gap;
        gap = gaps_on ? $urandom_range(0, 4) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cmd        <= cmd;
        i_row        <= row;
        i_col        <= col;
        i_cell_value <= value;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        items_accepted++;
        if (cmd == CMD_LOAD) begin
            heights[row * MAX_C + col] = value;
            memo_epoch++;
        end else begin
            pending_basins.push_back(predict_basin(row, col));
        end
    endtask

    task automatic query_cell(input int row, input int col);
        offer_item(CMD_QUERY, POS_W'(row), POS_W'(col), $urandom());
    endtask

    // Drop valid, let every expected result drain, then idle before returning.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_basins.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
        settle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == REG_GRID_ROWS) begin
            rows_reg = data;
            memo_epoch++;
        end else if (idx == REG_GRID_COLS) begin
            cols_reg = data;
            memo_epoch++;
        end
    endtask

    task automatic fill_area(input t_height_mix mix);
        int r, c;
        for (r = 0; r < int'(area_rows()); r++)
            for (c = 0; c < int'(area_cols()); c++)
                offer_item(CMD_LOAD, POS_W'(r), POS_W'(c), pick_height(mix));
    endtask

    task automatic query_outside();
        int unsigned er, ec;
        er = area_rows();
        ec = area_cols();
        if (er < MAX_R && (ec >= MAX_C || $urandom_range(0, 1) == 0))
            query_cell($urandom_range(er, MAX_R - 1), $urandom_range(0, MAX_C - 1));
        else
            query_cell($urandom_range(0, MAX_R - 1), $urandom_range(ec, MAX_C - 1));
    endtask

    // Reset size covers the whole store: query only minima whose neighborhoods are loaded.
    task automatic test_default_area();
        gaps_on = 1'b0;
        offer_item(CMD_LOAD, 8'd255, 8'd255, H_MIN);
        offer_item(CMD_LOAD, 8'd254, 8'd255, H_MAX);
        offer_item(CMD_LOAD, 8'd255, 8'd254, H_MAX);
        offer_item(CMD_LOAD, 8'd254, 8'd254, H_MAX);
        query_cell(255, 255);
        offer_item(CMD_LOAD, 8'd0, 8'd0, -1);
        offer_item(CMD_LOAD, 8'd0, 8'd1, 0);
        offer_item(CMD_LOAD, 8'd1, 8'd0, 0);
        offer_item(CMD_LOAD, 8'd1, 8'd1, 0);
        query_cell(0, 0);
    endtask

    task automatic test_tie_break();
        int i;
        write_reg(REG_GRID_ROWS, 9'd3);
        write_reg(REG_GRID_COLS, 9'd3);
        gaps_on = 1'b1;
        for (i = 0; i < 9; i++)
            offer_item(CMD_LOAD, POS_W'(i / 3), POS_W'(i % 3), TIE_GRID[i]);
        query_cell(1, 1);
        query_cell(0, 0);
        query_cell(0, 1);
        query_cell(1, 0);
        query_cell(2, 2);
        query_cell(1, 1);
        query_cell(3, 1);
        query_cell(1, 3);
    endtask

    task automatic test_special_cases();
        offer_item(CMD_LOAD, 8'd0, 8'd2, 100);
        query_cell(1, 1);
        write_reg(REG_GRID_COLS, 9'd2);
        query_cell(1, 1);
        query_cell(1, 2);
        // Store a cell that lies outside the area; it must stay invisible until the area grows.
        offer_item(CMD_LOAD, 8'd0, 8'd2, -50);
        query_cell(0, 1);
        write_reg(CFG_IDX_W'(REG_GRID_COLS + 1), 9'h1FF);
        query_cell(0, 1);
        write_reg(REG_GRID_COLS, 9'd3);
        query_cell(1, 1);
        write_reg(REG_GRID_ROWS, 9'd0);
        query_cell(0, 0);
        write_reg(REG_GRID_ROWS, 9'd3);
        write_reg(REG_GRID_COLS, 9'd0);
        query_cell(0, 0);
    endtask

    // Full-length strips give the longest descent paths; sizes above the maximum saturate.
    task automatic test_long_strips();
        int i;
        write_reg(REG_GRID_ROWS, 9'd511);
        write_reg(REG_GRID_COLS, 9'd1);
        gaps_on = 1'b0;
        for (i = 0; i < MAX_R; i++)
            offer_item(CMD_LOAD, POS_W'(i), 8'd0, (i == MAX_R - 1) ? H_MAX : H_MIN + i * 7);
        query_cell(MAX_R - 1, 0);
        query_cell(128, 0);
        write_reg(REG_GRID_ROWS, 9'd1);
        write_reg(REG_GRID_COLS, 9'd256);
        gaps_on = 1'b1;
        for (i = 0; i < MAX_C; i++)
            offer_item(CMD_LOAD, 8'd0, POS_W'(i),
                       (i == 0) ? H_MAX : (i == MAX_C - 1) ? H_MIN : 1000 - 3 * i);
        query_cell(0, 0);
        query_cell(0, 40);
    endtask

    task automatic test_backpressure();
        write_reg(REG_GRID_ROWS, 9'd4);
        write_reg(REG_GRID_COLS, 9'd4);
        gaps_on = 1'b1;
        fill_area(MIX_NARROW);
        hold_len = HOLD_CYCLES;
        repeat (12) query_cell($urandom_range(0, 3), $urandom_range(0, 3));
    endtask

    task automatic test_random_mix();
        int               sel, k, ops;
        logic [DIM_W-1:0] nr, nc, tmp;
        int unsigned      er, ec;
        t_height_mix      mix;
        while (items_accepted < ITEM_TARGET) begin
            sel = $urandom_range(0, 99);
            if (sel < 3) begin
                nr = DIM_W'($urandom_range(MAX_R, (1 << DIM_W) - 1));
                nc = 9'd1;
            end else if (sel < 9) begin
                nr = '0;
                nc = DIM_W'($urandom_range(0, (1 << DIM_W) - 1));
            end else begin
                nr = DIM_W'($urandom_range(1, 8));
                nc = DIM_W'($urandom_range(1, 8));
            end
            if ($urandom_range(0, 1) == 0) begin
                tmp = nr;
                nr  = nc;
                nc  = tmp;
            end
            write_reg(REG_GRID_ROWS, nr);
            write_reg(REG_GRID_COLS, nc);
            if ($urandom_range(0, 9) == 0)
                write_reg(CFG_IDX_W'($urandom_range(REG_GRID_COLS + 1, (1 << CFG_IDX_W) - 1)),
                          DIM_W'($urandom_range(0, (1 << DIM_W) - 1)));
            gaps_on = ($urandom_range(0, 3) != 0);
            mix     = t_height_mix'($urandom_range(0, 2));
            fill_area(mix);
            er  = area_rows();
            ec  = area_cols();
            ops = $urandom_range(10, 40);
            repeat (ops) begin
                k = $urandom_range(0, 99);
                if (k < 60 && er > 0 && ec > 0)
                    query_cell($urandom_range(0, er - 1), $urandom_range(0, ec - 1));
                else if (k < 78)
                    query_outside();
                else if (k < 95 && er > 0 && ec > 0)
                    offer_item(CMD_LOAD, POS_W'($urandom_range(0, er - 1)),
                               POS_W'($urandom_range(0, ec - 1)), pick_height(mix));
                else
                    offer_item(CMD_LOAD, POS_W'($urandom()), POS_W'($urandom()), $urandom());
            end
        end
    endtask

    initial begin : result_sink
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_len > 0) begin
                // Hold off long enough for the block to back up into its input.
                i_out_ready <= 1'b0;
                repeat (hold_len) @(posedge i_clk);
                hold_len = 0;
                @(negedge i_clk);
            end else begin
                stall = gaps_on ? $urandom_range(0, 4) : 0;
                if (stall > 0) begin
                    i_out_ready <= 1'b0;
                    do @(posedge i_clk); while (o_out_valid !== 1'b1);
                    repeat (stall - 1) @(posedge i_clk);
                    @(negedge i_clk);
                end
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            check_basin_result(o_basin_value, o_bad_address);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && i_out_ready)
                || (i_cfg_valid && o_cfg_ready === 1'b1))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin : run_tests
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_default_area();
        test_tie_break();
        test_special_cases();
        test_long_strips();
        test_backpressure();
        test_random_mix();
        settle();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
